// File: hdl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and constants of the searchable double-ended queue.
// ----------------------------------------------------------------------------
package sdq_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W      = 6;
	localparam int COUNT_W    = 7;
	localparam int VALUE_W    = 32;

	typedef enum logic [1:0] {
		OP_APPEND    = 2'd0,
		OP_POP_FRONT = 2'd1,
		OP_POP_BACK  = 2'd2,
		OP_SEARCH    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic                found;
		logic [POS_W-1:0]    position;
		logic [COUNT_W-1:0]  count;
	} rsp_t;

	typedef struct packed {
		logic                  append_en;
		logic                  shift_en;
		logic [DATA_WIDTH-1:0] key;
		logic [CNT_W-1:0]      count;
	} cell_ctl_t;

endpackage

// File: hdl/searchable_double_ended_queue.sv
// An accepted item is registered in the s1 registers, then in the result register.
// Throughput: one item per cycle unless stalled; the row of slots compares
// every entry at once; a pop front shifts the whole row in the same cycle.
// Stall on the result side backs up through one stage to the request side.
// Reset clears the fill count and both stage valids; entry contents are
// undefined until written.
// ----------------------------------------------------------------------------
// searchable_double_ended_queue
// Bounded queue with append, front and back removal, and linear search.
// ----------------------------------------------------------------------------
module searchable_double_ended_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sdq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sdq_pkg::rsp_t rsp
);

	localparam int CW  = sdq_pkg::CNT_W;
	localparam int IW  = sdq_pkg::IDX_W;
	localparam int DW  = sdq_pkg::DATA_WIDTH;
	localparam int PW  = sdq_pkg::POS_W;
	localparam int OW  = sdq_pkg::COUNT_W;
	localparam int N   = sdq_pkg::DEPTH;
	localparam logic [CW-1:0] FULL = CW'(N);

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	sdq_pkg::status_t    status_nxt;
	sdq_pkg::cell_ctl_t  ctl;
	logic                accept;
	logic [DW-1:0]       data [N];
	logic [N-1:0]        hits;

	logic                valid_s1;
	logic                search_s1;
	logic [N-1:0]        hits_s1;
	sdq_pkg::status_t    status_s1;
	logic [CW-1:0]       count_s1;

	logic                out_load;
	logic                any;
	logic [IW-1:0]       first;
	logic                rsp_valid_q;
	sdq_pkg::rsp_t       rsp_q;

	assign out_load  = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !out_load;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = sdq_pkg::ST_DONE;
		unique case (req.op)
			sdq_pkg::OP_APPEND: begin
				if (count_q == FULL) status_nxt = sdq_pkg::ST_FULL;
				else count_nxt = count_q + CW'(1);
			end
			sdq_pkg::OP_POP_FRONT, sdq_pkg::OP_POP_BACK: begin
				if (count_q == '0) status_nxt = sdq_pkg::ST_EMPTY;
				else count_nxt = count_q - CW'(1);
			end
			sdq_pkg::OP_SEARCH: begin
				count_nxt = count_q;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	assign ctl.append_en = accept && (req.op == sdq_pkg::OP_APPEND);
	assign ctl.shift_en  = accept && (req.op == sdq_pkg::OP_POP_FRONT) && (count_q != '0);
	assign ctl.key       = req.value[DW-1:0];
	assign ctl.count     = count_q;

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [DW-1:0] nbr;
		if (g == N - 1) begin : g_last
			assign nbr = data[g];
		end else begin : g_mid
			assign nbr = data[g+1];
		end
		sdq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (IW'(g)),
			.next_data (nbr),
			.data      (data[g]),
			.match     (hits[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) count_q <= count_nxt;
			if (accept) valid_s1 <= 1'b1;
			else if (out_load) valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			search_s1 <= (req.op == sdq_pkg::OP_SEARCH);
			hits_s1   <= hits;
			status_s1 <= status_nxt;
			count_s1  <= count_nxt;
		end
	end

	sdq_pick u_pick (
		.hits  (hits_s1),
		.any   (any),
		.first (first)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.status   <= status_s1;
			rsp_q.found    <= search_s1 && any;
			rsp_q.position <= (search_s1 && any) ? PW'(first) : '0;
			rsp_q.count    <= OW'(count_s1);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/sdq_cell.sv
// ----------------------------------------------------------------------------
// sdq_cell
// One queue slot: holds an entry, loads on append, takes its neighbor's
// entry on a front removal, and compares against the search key.
// ----------------------------------------------------------------------------
module sdq_cell (
	input  logic                           clk,
	input  sdq_pkg::cell_ctl_t             ctl,
	input  logic [sdq_pkg::IDX_W-1:0]      idx,
	input  logic [sdq_pkg::DATA_WIDTH-1:0] next_data,
	output logic [sdq_pkg::DATA_WIDTH-1:0] data,
	output logic                           match
);

	localparam int CW = sdq_pkg::CNT_W;

	logic [sdq_pkg::DATA_WIDTH-1:0] data_q;
	logic [CW-1:0]                  idx_ext;

	assign idx_ext = CW'(idx);
	assign data    = data_q;
	assign match   = (idx_ext < ctl.count) && (data_q == ctl.key);

	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			data_q <= next_data;
		end else if (ctl.append_en && (idx_ext == ctl.count)) begin
			data_q <= ctl.key;
		end
	end

endmodule

// File: hdl/sdq_pick.sv
// ----------------------------------------------------------------------------
// sdq_pick
// Priority pick of the lowest matching slot.
// ----------------------------------------------------------------------------
module sdq_pick (
	input  logic [sdq_pkg::DEPTH-1:0] hits,
	output logic                      any,
	output logic [sdq_pkg::IDX_W-1:0] first
);

	localparam int IW = sdq_pkg::IDX_W;

	always_comb begin
		any   = |hits;
		first = '0;
		for (int i = sdq_pkg::DEPTH - 1; i >= 0; i--) begin
			if (hits[i]) begin
				first = IW'(i);
			end
		end
	end

endmodule

// File: hdl/sdq_checker.sv
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks of the searchable double-ended queue.
// ----------------------------------------------------------------------------
module sdq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input sdq_pkg::rsp_t rsp
);

	localparam int OW = sdq_pkg::COUNT_W;
	localparam logic [OW-1:0] FULL = OW'(sdq_pkg::DEPTH);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.count <= FULL)
		else $error("count above depth");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == sdq_pkg::ST_FULL |-> rsp.count == FULL && !rsp.found)
		else $error("full status with room left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == sdq_pkg::ST_EMPTY |-> rsp.count == '0 && !rsp.found)
		else $error("empty status with entries held");

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.found ? (OW'(rsp.position) < rsp.count) : (rsp.position == '0)))
		else $error("position outside held entries");

endmodule

bind searchable_double_ended_queue sdq_checker u_sdq_checker (.*);
